/* rtl/ecpu_pkg.sv */
// Package: shared types, opcode codes and decode functions for the 6502 instruction core.
`default_nettype none

package ecpu_pkg;

    localparam int ECPU_MEM_ADDR_BITS = 16;

    // Item commands
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SET_PC = 2'd2,
        CMD_EXEC   = 2'd3
    } cmd_t;

    // Addressing modes
    typedef enum logic [3:0] {
        AM_NONE, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABX, AM_ABY,
        AM_IZX, AM_IZY, AM_IND
    } amode_t;

    // Instruction classes as the sequencer sees them
    typedef enum logic [3:0] {
        K_IMPL, K_LOAD, K_STORE, K_RMW, K_BRANCH, K_JMP, K_JSR, K_BRK,
        K_PHA, K_PHP, K_PLA, K_PLP, K_RTI, K_RTS
    } kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_RDWAIT, ST_OPC, ST_OPL, ST_OPH, ST_PTRL, ST_PTRH,
        ST_OPND, ST_PUSH, ST_PULL, ST_VECL, ST_VECH, ST_WRES
    } state_t;

    typedef struct packed {
        amode_t     mode;
        kind_t      kind;
        logic [1:0] len;
    } dec_t;

    // Register file and operand into the ALU
    typedef struct packed {
        logic [7:0] op;
        logic [7:0] v;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] f;
    } alu_in_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] f;
        logic [7:0] wval;
    } alu_out_t;

    // Status bit positions
    localparam int FB_C = 0;
    localparam int FB_Z = 1;
    localparam int FB_I = 2;
    localparam int FB_D = 3;
    localparam int FB_B = 4;
    localparam int FB_U = 5;
    localparam int FB_V = 6;
    localparam int FB_N = 7;

    // Opcode groups
    localparam logic [1:0] CC_ALU = 2'b01;
    localparam logic [1:0] CC_RMW = 2'b10;

    localparam logic [2:0] AAA_ORA = 3'd0;
    localparam logic [2:0] AAA_AND = 3'd1;
    localparam logic [2:0] AAA_EOR = 3'd2;
    localparam logic [2:0] AAA_ADC = 3'd3;
    localparam logic [2:0] AAA_STA = 3'd4;
    localparam logic [2:0] AAA_LDA = 3'd5;
    localparam logic [2:0] AAA_CMP = 3'd6;
    localparam logic [2:0] AAA_SBC = 3'd7;

    localparam logic [2:0] AAA_ASL = 3'd0;
    localparam logic [2:0] AAA_ROL = 3'd1;
    localparam logic [2:0] AAA_LSR = 3'd2;
    localparam logic [2:0] AAA_ROR = 3'd3;
    localparam logic [2:0] AAA_STX = 3'd4;
    localparam logic [2:0] AAA_LDX = 3'd5;
    localparam logic [2:0] AAA_DEC = 3'd6;
    localparam logic [2:0] AAA_INC = 3'd7;

    localparam logic [2:0] BBB_IMM = 3'd0;
    localparam logic [2:0] BBB_ZP  = 3'd1;
    localparam logic [2:0] BBB_ACC = 3'd2;
    localparam logic [2:0] BBB_ABS = 3'd3;
    localparam logic [2:0] BBB_ZPI = 3'd5;
    localparam logic [2:0] BBB_STK = 3'd6;
    localparam logic [2:0] BBB_ABI = 3'd7;

    localparam logic [4:0] BRANCH_PAT = 5'b10000;

    // Opcodes handled one by one
    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_PHP     = 8'h08;
    localparam logic [7:0] OP_CLC     = 8'h18;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_BIT_ZP  = 8'h24;
    localparam logic [7:0] OP_PLP     = 8'h28;
    localparam logic [7:0] OP_BIT_ABS = 8'h2C;
    localparam logic [7:0] OP_SEC     = 8'h38;
    localparam logic [7:0] OP_RTI     = 8'h40;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_JMP_ABS = 8'h4C;
    localparam logic [7:0] OP_CLI     = 8'h58;
    localparam logic [7:0] OP_RTS     = 8'h60;
    localparam logic [7:0] OP_PLA     = 8'h68;
    localparam logic [7:0] OP_JMP_IND = 8'h6C;
    localparam logic [7:0] OP_SEI     = 8'h78;
    localparam logic [7:0] OP_STY_ZP  = 8'h84;
    localparam logic [7:0] OP_DEY     = 8'h88;
    localparam logic [7:0] OP_NOP_89  = 8'h89;
    localparam logic [7:0] OP_STY_ABS = 8'h8C;
    localparam logic [7:0] OP_STY_ZPX = 8'h94;
    localparam logic [7:0] OP_TYA     = 8'h98;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
    localparam logic [7:0] OP_TAY     = 8'hA8;
    localparam logic [7:0] OP_LDY_ABS = 8'hAC;
    localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
    localparam logic [7:0] OP_CLV     = 8'hB8;
    localparam logic [7:0] OP_LDY_ABX = 8'hBC;
    localparam logic [7:0] OP_CPY_IMM = 8'hC0;
    localparam logic [7:0] OP_CPY_ZP  = 8'hC4;
    localparam logic [7:0] OP_INY     = 8'hC8;
    localparam logic [7:0] OP_CPY_ABS = 8'hCC;
    localparam logic [7:0] OP_CLD     = 8'hD8;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_CPX_ZP  = 8'hE4;
    localparam logic [7:0] OP_INX     = 8'hE8;
    localparam logic [7:0] OP_CPX_ABS = 8'hEC;
    localparam logic [7:0] OP_SED     = 8'hF8;

    // N and Z from a result byte
    function automatic logic [7:0] set_nz(logic [7:0] f, logic [7:0] v);
        logic [7:0] r;
        r       = f;
        r[FB_N] = v[7];
        r[FB_Z] = (v == 8'h00);
        return r;
    endfunction

    // Mode of the main ALU group from bits 4..2
    function automatic amode_t alu_mode(logic [2:0] bbb);
        amode_t m;
        unique case (bbb)
            3'd0:    m = AM_IZX;
            3'd1:    m = AM_ZP;
            3'd2:    m = AM_IMM;
            3'd3:    m = AM_ABS;
            3'd4:    m = AM_IZY;
            3'd5:    m = AM_ZPX;
            3'd6:    m = AM_ABY;
            default: m = AM_ABX;
        endcase
        return m;
    endfunction

    // Full opcode decode
    function automatic dec_t ecpu_decode(logic [7:0] op);
        dec_t       d;
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic       xy;
        aaa    = op[7:5];
        bbb    = op[4:2];
        xy     = (aaa == AAA_STX) || (aaa == AAA_LDX);
        d.mode = AM_NONE;
        d.kind = K_IMPL;
        d.len  = 2'd1;
        if (op[1:0] == CC_ALU) begin
            if (op != OP_NOP_89) begin
                d.mode = alu_mode(bbb);
                d.kind = (aaa == AAA_STA) ? K_STORE : K_LOAD;
            end
        end else if (op[1:0] == CC_RMW) begin
            if (bbb == BBB_ZP) d.mode = AM_ZP;
            else if (bbb == BBB_ABS) d.mode = AM_ABS;
            else if (bbb == BBB_ZPI) d.mode = xy ? AM_ZPY : AM_ZPX;
            else if (bbb == BBB_ABI && aaa != AAA_STX) d.mode = xy ? AM_ABY : AM_ABX;
            else if (bbb == BBB_IMM && aaa == AAA_LDX) d.mode = AM_IMM;
            if (d.mode != AM_NONE) begin
                if (aaa == AAA_STX) d.kind = K_STORE;
                else if (aaa == AAA_LDX) d.kind = K_LOAD;
                else d.kind = K_RMW;
            end
        end else if (op[4:0] == BRANCH_PAT) begin
            d.kind = K_BRANCH;
        end else begin
            unique case (op)
                OP_BRK:     d.kind = K_BRK;
                OP_PHP:     d.kind = K_PHP;
                OP_PLP:     d.kind = K_PLP;
                OP_PHA:     d.kind = K_PHA;
                OP_PLA:     d.kind = K_PLA;
                OP_RTI:     d.kind = K_RTI;
                OP_RTS:     d.kind = K_RTS;
                OP_JSR:     begin d.kind = K_JSR;  d.mode = AM_ABS; end
                OP_JMP_ABS: begin d.kind = K_JMP;  d.mode = AM_ABS; end
                OP_JMP_IND: begin d.kind = K_JMP;  d.mode = AM_IND; end
                OP_BIT_ZP:  begin d.kind = K_LOAD; d.mode = AM_ZP;  end
                OP_BIT_ABS: begin d.kind = K_LOAD; d.mode = AM_ABS; end
                OP_STY_ZP:  begin d.kind = K_STORE; d.mode = AM_ZP;  end
                OP_STY_ABS: begin d.kind = K_STORE; d.mode = AM_ABS; end
                OP_STY_ZPX: begin d.kind = K_STORE; d.mode = AM_ZPX; end
                OP_LDY_IMM, OP_CPY_IMM, OP_CPX_IMM: begin
                    d.kind = K_LOAD; d.mode = AM_IMM;
                end
                OP_LDY_ZP, OP_CPY_ZP, OP_CPX_ZP: begin
                    d.kind = K_LOAD; d.mode = AM_ZP;
                end
                OP_LDY_ABS, OP_CPY_ABS, OP_CPX_ABS: begin
                    d.kind = K_LOAD; d.mode = AM_ABS;
                end
                OP_LDY_ZPX: begin d.kind = K_LOAD; d.mode = AM_ZPX; end
                OP_LDY_ABX: begin d.kind = K_LOAD; d.mode = AM_ABX; end
                default:    d.kind = K_IMPL;
            endcase
        end
        // Instruction length for the PC advance
        if (d.kind == K_BRANCH) d.len = 2'd2;
        else if (d.mode == AM_ABS || d.mode == AM_ABX || d.mode == AM_ABY) d.len = 2'd3;
        else if (d.mode != AM_NONE) d.len = 2'd2;
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/ecpu_mem.sv */
// Byte memory: one write port and one registered read port.
`default_nettype none

module ecpu_mem #(
    parameter int ADDR_BITS = ecpu_pkg::ECPU_MEM_ADDR_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [7:0]           wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [7:0]           rd_data
);
    import ecpu_pkg::*;

    logic [7:0] ram [2**ADDR_BITS];
    logic [7:0] rdata_reg;

    // Write port, and a read every cycle, registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        rdata_reg <= ram[rd_addr];
    end

    assign rd_data = rdata_reg;

endmodule

`default_nettype wire

/* rtl/ecpu_alu.sv */
// Instruction ALU: register, flag and store-value results for one opcode.
`default_nettype none

module ecpu_alu (
    input  wire ecpu_pkg::alu_in_t  alu_in,
    output ecpu_pkg::alu_out_t      alu_out
);
    import ecpu_pkg::*;

    // Binary add with carry in; returns {flags, sum}
    function automatic logic [15:0] do_adc(logic [7:0] a, logic [7:0] m, logic [7:0] f);
        logic [8:0] s;
        logic [7:0] vx;
        logic [7:0] nf;
        s        = {1'b0, a} + {1'b0, m} + {8'h00, f[FB_C]};
        vx       = ~(a ^ m) & (a ^ s[7:0]);
        nf       = f;
        nf[FB_V] = vx[7];
        nf[FB_C] = s[8];
        nf       = set_nz(nf, s[7:0]);
        return {nf, s[7:0]};
    endfunction

    // Compare; returns the new flags
    function automatic logic [7:0] do_cmp(logic [7:0] r, logic [7:0] m, logic [7:0] f);
        logic [7:0] nf;
        nf       = f;
        nf[FB_C] = (r >= m);
        nf       = set_nz(nf, 8'(r - m));
        return nf;
    endfunction

    // Shifts, rotates, increment and decrement; returns {flags, result}
    function automatic logic [15:0] do_shift(logic [2:0] k, logic [7:0] v, logic [7:0] f);
        logic [7:0] r;
        logic       c;
        logic [7:0] nf;
        c = f[FB_C];
        unique case (k)
            AAA_ASL: begin c = v[7]; r = {v[6:0], 1'b0}; end
            AAA_ROL: begin c = v[7]; r = {v[6:0], f[FB_C]}; end
            AAA_LSR: begin c = v[0]; r = {1'b0, v[7:1]}; end
            AAA_ROR: begin c = v[0]; r = {f[FB_C], v[7:1]}; end
            AAA_DEC: r = v - 8'd1;
            default: r = v + 8'd1;
        endcase
        nf       = f;
        nf[FB_C] = c;
        nf       = set_nz(nf, r);
        return {nf, r};
    endfunction

    logic [2:0] aaa;
    logic [2:0] bbb;
    logic       is_mem;

    assign aaa = alu_in.op[7:5];
    assign bbb = alu_in.op[4:2];
    assign is_mem = (bbb == BBB_ZP) || (bbb == BBB_ABS) || (bbb == BBB_ZPI) ||
                    ((bbb == BBB_ABI) && (aaa != AAA_STX)) ||
                    ((bbb == BBB_IMM) && (aaa == AAA_LDX));

    // Per-opcode results
    always_comb begin
        alu_out.a    = alu_in.a;
        alu_out.x    = alu_in.x;
        alu_out.y    = alu_in.y;
        alu_out.s    = alu_in.s;
        alu_out.f    = alu_in.f;
        alu_out.wval = 8'h00;
        if (alu_in.op[1:0] == CC_ALU) begin
            if (alu_in.op != OP_NOP_89) begin
                unique case (aaa)
                    AAA_ORA: begin
                        alu_out.a = alu_in.a | alu_in.v;
                        alu_out.f = set_nz(alu_in.f, alu_in.a | alu_in.v);
                    end
                    AAA_AND: begin
                        alu_out.a = alu_in.a & alu_in.v;
                        alu_out.f = set_nz(alu_in.f, alu_in.a & alu_in.v);
                    end
                    AAA_EOR: begin
                        alu_out.a = alu_in.a ^ alu_in.v;
                        alu_out.f = set_nz(alu_in.f, alu_in.a ^ alu_in.v);
                    end
                    AAA_ADC: {alu_out.f, alu_out.a} = do_adc(alu_in.a, alu_in.v, alu_in.f);
                    AAA_STA: alu_out.wval = alu_in.a;
                    AAA_LDA: begin
                        alu_out.a = alu_in.v;
                        alu_out.f = set_nz(alu_in.f, alu_in.v);
                    end
                    AAA_CMP: alu_out.f = do_cmp(alu_in.a, alu_in.v, alu_in.f);
                    default: {alu_out.f, alu_out.a} = do_adc(alu_in.a, ~alu_in.v, alu_in.f);
                endcase
            end
        end else if (alu_in.op[1:0] == CC_RMW) begin
            if (is_mem) begin
                if (aaa == AAA_STX) begin
                    alu_out.wval = alu_in.x;
                end else if (aaa == AAA_LDX) begin
                    alu_out.x = alu_in.v;
                    alu_out.f = set_nz(alu_in.f, alu_in.v);
                end else begin
                    {alu_out.f, alu_out.wval} = do_shift(aaa, alu_in.v, alu_in.f);
                end
            end else if (bbb == BBB_ACC) begin
                if (!aaa[2]) begin
                    {alu_out.f, alu_out.a} = do_shift(aaa, alu_in.a, alu_in.f);
                end else if (aaa == AAA_STX) begin
                    alu_out.a = alu_in.x;
                    alu_out.f = set_nz(alu_in.f, alu_in.x);
                end else if (aaa == AAA_LDX) begin
                    alu_out.x = alu_in.a;
                    alu_out.f = set_nz(alu_in.f, alu_in.a);
                end else if (aaa == AAA_DEC) begin
                    {alu_out.f, alu_out.x} = do_shift(AAA_DEC, alu_in.x, alu_in.f);
                end
            end else if (bbb == BBB_STK) begin
                if (aaa == AAA_STX) begin
                    alu_out.s = alu_in.x;
                end else if (aaa == AAA_LDX) begin
                    alu_out.x = alu_in.s;
                    alu_out.f = set_nz(alu_in.f, alu_in.s);
                end
            end
        end else begin
            unique case (alu_in.op)
                OP_BRK: begin
                    alu_out.wval       = alu_in.f | 8'h30;
                    alu_out.f[FB_I]    = 1'b1;
                end
                OP_PHP: alu_out.wval = alu_in.f | 8'h30;
                OP_PHA: alu_out.wval = alu_in.a;
                OP_PLA: begin
                    alu_out.a = alu_in.v;
                    alu_out.f = set_nz(alu_in.f, alu_in.v);
                end
                OP_PLP, OP_RTI: begin
                    alu_out.f        = alu_in.v;
                    alu_out.f[FB_U]  = 1'b0;
                end
                OP_CLC: alu_out.f[FB_C] = 1'b0;
                OP_SEC: alu_out.f[FB_C] = 1'b1;
                OP_CLI: alu_out.f[FB_I] = 1'b0;
                OP_SEI: alu_out.f[FB_I] = 1'b1;
                OP_CLV: alu_out.f[FB_V] = 1'b0;
                OP_CLD: alu_out.f[FB_D] = 1'b0;
                OP_SED: alu_out.f[FB_D] = 1'b1;
                OP_BIT_ZP, OP_BIT_ABS: begin
                    alu_out.f[FB_N] = alu_in.v[7];
                    alu_out.f[FB_V] = alu_in.v[6];
                    alu_out.f[FB_Z] = ((alu_in.a & alu_in.v) == 8'h00);
                end
                OP_STY_ZP, OP_STY_ABS, OP_STY_ZPX: alu_out.wval = alu_in.y;
                OP_DEY: {alu_out.f, alu_out.y} = do_shift(AAA_DEC, alu_in.y, alu_in.f);
                OP_INY: {alu_out.f, alu_out.y} = do_shift(AAA_INC, alu_in.y, alu_in.f);
                OP_INX: {alu_out.f, alu_out.x} = do_shift(AAA_INC, alu_in.x, alu_in.f);
                OP_TYA: begin
                    alu_out.a = alu_in.y;
                    alu_out.f = set_nz(alu_in.f, alu_in.y);
                end
                OP_TAY: begin
                    alu_out.y = alu_in.a;
                    alu_out.f = set_nz(alu_in.f, alu_in.a);
                end
                OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABX: begin
                    alu_out.y = alu_in.v;
                    alu_out.f = set_nz(alu_in.f, alu_in.v);
                end
                OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS:
                    alu_out.f = do_cmp(alu_in.y, alu_in.v, alu_in.f);
                OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS:
                    alu_out.f = do_cmp(alu_in.x, alu_in.v, alu_in.f);
                default: alu_out.wval = 8'h00;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/eight_bit_cpu_instruction_core.sv */
// Top level: 6502 instruction core, sequencer around a byte memory with one
// write port and one registered read port. Of the commands, execute takes longest,
// BRK the longest of all opcodes. Throughput is one item at a time; the next item is
// taken as soon as the previous result sits in the output register.
// Reset: A, X, Y, PC and flags clear, stack pointer 0xFF; memory is not cleared.
`default_nettype none

module eight_bit_cpu_instruction_core #(
    parameter int MEM_ADDR_BITS = ecpu_pkg::ECPU_MEM_ADDR_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [15:0] s_address,
    input  wire logic [7:0]  s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic [7:0]       m_reg_a,
    output logic [7:0]       m_reg_x,
    output logic [7:0]       m_reg_y,
    output logic [7:0]       m_stack_ptr,
    output logic [15:0]      m_prog_counter,
    output logic [7:0]       m_flags_byte,
    output logic [7:0]       m_opcode_done
);
    import ecpu_pkg::*;

    state_t      state_reg, state_next;
    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next, sp_reg, sp_next;
    logic [7:0]  f_reg, f_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  op_reg, op_next, lo_reg, lo_next, ptr_reg, ptr_next;
    logic [15:0] ea_reg, ea_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  res_rd_reg, res_rd_next, res_op_reg, res_op_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  o_rd_reg, o_rd_next, o_a_reg, o_a_next, o_x_reg, o_x_next;
    logic [7:0]  o_y_reg, o_y_next, o_sp_reg, o_sp_next, o_f_reg, o_f_next;
    logic [7:0]  o_op_reg, o_op_next;
    logic [15:0] o_pc_reg, o_pc_next;

    logic        mem_we;
    logic [15:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, mem_rdata;

    dec_t        dec;
    alu_in_t     alu_in;
    alu_out_t    alu_out;
    logic        ptr_mode, disp_en, take, flag_sel, push_last, pull_last, out_load;
    logic [15:0] ea_direct, ea_ptr, ea_go, hilo, pc_len, ret_addr;
    logic [7:0]  push_val;

    ecpu_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa[MEM_ADDR_BITS-1:0]),
        .wr_data (mem_wd),
        .rd_addr (mem_ra[MEM_ADDR_BITS-1:0]),
        .rd_data (mem_rdata)
    );

    assign alu_in = '{op: op_reg, v: mem_rdata, a: a_reg, x: x_reg, y: y_reg,
                      s: sp_reg, f: f_reg};

    ecpu_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    // Decode and address arithmetic
    assign dec      = ecpu_decode(op_reg);
    assign hilo     = {mem_rdata, lo_reg};
    assign pc_len   = pc_reg + {14'd0, dec.len};
    assign ret_addr = pc_reg + 16'd2;
    assign ptr_mode = (dec.mode == AM_IZX) || (dec.mode == AM_IZY) || (dec.mode == AM_IND);
    assign ea_ptr   = (dec.mode == AM_IZY) ? hilo + {8'h00, y_reg} : hilo;
    assign ea_go    = (state_reg == ST_OPH) ? ea_direct : ea_ptr;
    assign disp_en  = ((state_reg == ST_OPH) && !ptr_mode) ||
                      ((state_reg == ST_PTRH) && (dec.mode != AM_IND));
    assign push_last = (cnt_reg == 2'd2) || ((dec.kind == K_JSR) && (cnt_reg == 2'd1));
    assign pull_last = (dec.kind == K_PLA) || (dec.kind == K_PLP) ||
                       ((dec.kind == K_RTS) && (cnt_reg == 2'd1)) ||
                       ((dec.kind == K_RTI) && (cnt_reg == 2'd2));
    assign out_load  = (state_reg == ST_WRES) && (!m_valid_reg || m_ready);

    always_comb begin
        unique case (dec.mode)
            AM_IMM:  ea_direct = pc_reg + 16'd1;
            AM_ZP:   ea_direct = {8'h00, lo_reg};
            AM_ZPX:  ea_direct = {8'h00, 8'(lo_reg + x_reg)};
            AM_ZPY:  ea_direct = {8'h00, 8'(lo_reg + y_reg)};
            AM_ABX:  ea_direct = hilo + {8'h00, x_reg};
            AM_ABY:  ea_direct = hilo + {8'h00, y_reg};
            default: ea_direct = hilo;
        endcase
    end

    // Branch condition: N, V, C, Z by bits 7..6, wanted value in bit 5
    always_comb begin
        unique case (op_reg[7:6])
            2'd0:    flag_sel = f_reg[FB_N];
            2'd1:    flag_sel = f_reg[FB_V];
            2'd2:    flag_sel = f_reg[FB_C];
            default: flag_sel = f_reg[FB_Z];
        endcase
        take = (flag_sel == op_reg[5]);
    end

    // Stack beat value: return high, return low, then status or accumulator
    always_comb begin
        unique case (cnt_reg)
            2'd0:    push_val = ret_addr[15:8];
            2'd1:    push_val = ret_addr[7:0];
            default: push_val = alu_out.wval;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_t'(s_cmd))
                        CMD_READ: state_next = ST_RDWAIT;
                        CMD_EXEC: state_next = ST_OPC;
                        default:  state_next = ST_WRES;
                    endcase
                end
            end
            ST_RDWAIT: state_next = ST_WRES;
            ST_OPC:    state_next = ST_OPL;
            ST_OPL:    state_next = ST_OPH;
            ST_OPH:    state_next = ptr_mode ? ST_PTRL : ST_WRES;
            ST_PTRL:   state_next = ST_PTRH;
            ST_PTRH:   state_next = ST_WRES;
            ST_OPND:   state_next = ST_WRES;
            ST_PUSH: begin
                if (push_last) state_next = (dec.kind == K_BRK) ? ST_VECL : ST_WRES;
            end
            ST_PULL: begin
                if (pull_last) state_next = ST_WRES;
            end
            ST_VECL:   state_next = ST_VECH;
            ST_VECH:   state_next = ST_WRES;
            ST_WRES: begin
                if (out_load) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
        // Dispatch once the effective address is known
        if (disp_en) begin
            unique case (dec.kind)
                K_LOAD, K_RMW:               state_next = ST_OPND;
                K_JSR, K_BRK, K_PHA, K_PHP:  state_next = ST_PUSH;
                K_PLA, K_PLP, K_RTI, K_RTS:  state_next = ST_PULL;
                default:                     state_next = ST_WRES;
            endcase
        end
    end

    // Datapath and memory port
    always_comb begin
        a_next = a_reg; x_next = x_reg; y_next = y_reg; sp_next = sp_reg;
        f_next = f_reg; pc_next = pc_reg;
        op_next = op_reg; lo_next = lo_reg; ptr_next = ptr_reg; ea_next = ea_reg;
        cnt_next = cnt_reg; res_rd_next = res_rd_reg; res_op_next = res_op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        o_rd_next = o_rd_reg; o_a_next = o_a_reg; o_x_next = o_x_reg; o_y_next = o_y_reg;
        o_sp_next = o_sp_reg; o_f_next = o_f_reg; o_pc_next = o_pc_reg; o_op_next = o_op_reg;
        mem_we = 1'b0; mem_wa = ea_reg; mem_wd = alu_out.wval; mem_ra = pc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_rd_next = 8'h00;
                    res_op_next = 8'h00;
                    unique case (cmd_t'(s_cmd))
                        CMD_WRITE: begin
                            mem_we = 1'b1;
                            mem_wa = s_address;
                            mem_wd = s_write_data;
                        end
                        CMD_READ:   mem_ra  = s_address;
                        CMD_SET_PC: pc_next = s_address;
                        default:    mem_ra  = pc_reg;
                    endcase
                end
            end
            ST_RDWAIT: res_rd_next = mem_rdata;
            ST_OPC: begin
                op_next     = mem_rdata;
                res_op_next = mem_rdata;
                mem_ra      = pc_reg + 16'd1;
            end
            ST_OPL: begin
                lo_next = mem_rdata;
                mem_ra  = pc_reg + 16'd2;
            end
            ST_OPH: begin
                unique case (dec.mode)
                    AM_IZX: begin
                        ptr_next = lo_reg + x_reg;
                        mem_ra   = {8'h00, 8'(lo_reg + x_reg)};
                    end
                    AM_IZY: begin
                        ptr_next = lo_reg;
                        mem_ra   = {8'h00, lo_reg};
                    end
                    AM_IND: begin
                        ea_next = hilo;
                        mem_ra  = hilo;
                    end
                    default: mem_ra = ea_direct;
                endcase
            end
            // Pointer low byte; JMP indirect stays inside its page
            ST_PTRL: begin
                lo_next = mem_rdata;
                if (dec.mode == AM_IND) mem_ra = {ea_reg[15:8], 8'(ea_reg[7:0] + 8'd1)};
                else mem_ra = {8'h00, 8'(ptr_reg + 8'd1)};
            end
            ST_PTRH: begin
                if (dec.mode == AM_IND) pc_next = hilo;
            end
            ST_OPND: begin
                a_next = alu_out.a; x_next = alu_out.x; y_next = alu_out.y;
                sp_next = alu_out.s; f_next = alu_out.f;
                if (dec.kind == K_RMW) begin
                    mem_we = 1'b1;
                    mem_wa = ea_reg;
                    mem_wd = alu_out.wval;
                end
                pc_next = pc_len;
            end
            ST_PUSH: begin
                mem_we   = 1'b1;
                mem_wa   = {8'h01, sp_reg};
                mem_wd   = push_val;
                cnt_next = cnt_reg + 2'd1;
                if (push_last) begin
                    unique case (dec.kind)
                        K_JSR:   pc_next = ea_reg;
                        K_BRK: begin
                            f_next = alu_out.f;
                            mem_ra = 16'hFFFE;
                        end
                        default: pc_next = pc_reg + 16'd1;
                    endcase
                end
                sp_next = sp_reg - 8'd1;
            end
            ST_PULL: begin
                unique case (dec.kind)
                    K_PLA, K_PLP: begin
                        a_next  = alu_out.a;
                        f_next  = alu_out.f;
                        pc_next = pc_reg + 16'd1;
                    end
                    K_RTI: begin
                        if (cnt_reg == 2'd0) f_next = alu_out.f;
                        else if (cnt_reg == 2'd1) lo_next = mem_rdata;
                        else pc_next = hilo;
                    end
                    default: begin
                        if (cnt_reg == 2'd0) lo_next = mem_rdata;
                        else pc_next = hilo + 16'd1;
                    end
                endcase
                if (!pull_last) begin
                    mem_ra   = {8'h01, 8'(sp_reg + 8'd1)};
                    sp_next  = sp_reg + 8'd1;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_VECL: begin
                lo_next = mem_rdata;
                mem_ra  = 16'hFFFF;
            end
            ST_VECH: pc_next = hilo;
            ST_WRES: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    o_rd_next = res_rd_reg; o_a_next = a_reg; o_x_next = x_reg;
                    o_y_next = y_reg; o_sp_next = sp_reg; o_pc_next = pc_reg;
                    o_f_next = f_reg | 8'h20; o_op_next = res_op_reg;
                end
            end
            default: mem_ra = pc_reg;
        endcase
        // Effective address ready: issue the operand access
        if (disp_en) begin
            ea_next = ea_go;
            unique case (dec.kind)
                K_LOAD, K_RMW: mem_ra = ea_go;
                K_STORE: begin
                    mem_we  = 1'b1;
                    mem_wa  = ea_go;
                    mem_wd  = alu_out.wval;
                    pc_next = pc_len;
                end
                K_BRANCH: begin
                    pc_next = take ? ret_addr + {{8{lo_reg[7]}}, lo_reg} : ret_addr;
                end
                K_JMP:        pc_next  = ea_go;
                K_JSR, K_BRK: cnt_next = 2'd0;
                K_PHA, K_PHP: cnt_next = 2'd2;
                K_PLA, K_PLP, K_RTI, K_RTS: begin
                    mem_ra   = {8'h01, 8'(sp_reg + 8'd1)};
                    sp_next  = sp_reg + 8'd1;
                    cnt_next = 2'd0;
                end
                default: begin
                    a_next = alu_out.a; x_next = alu_out.x; y_next = alu_out.y;
                    sp_next = alu_out.s; f_next = alu_out.f;
                    pc_next = pc_reg + 16'd1;
                end
            endcase
        end
    end

    // Control and register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            a_reg       <= 8'h00;
            x_reg       <= 8'h00;
            y_reg       <= 8'h00;
            sp_reg      <= 8'hFF;
            f_reg       <= 8'h00;
            pc_reg      <= 16'h0000;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            a_reg       <= a_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            sp_reg      <= sp_next;
            f_reg       <= f_next;
            pc_reg      <= pc_next;
        end
    end

    // Working and output payload
    always_ff @(posedge aclk) begin
        op_reg <= op_next; lo_reg <= lo_next; ptr_reg <= ptr_next; ea_reg <= ea_next;
        cnt_reg <= cnt_next; res_rd_reg <= res_rd_next; res_op_reg <= res_op_next;
        o_rd_reg <= o_rd_next; o_a_reg <= o_a_next; o_x_reg <= o_x_next;
        o_y_reg <= o_y_next; o_sp_reg <= o_sp_next; o_f_reg <= o_f_next;
        o_pc_reg <= o_pc_next; o_op_reg <= o_op_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_read_data    = o_rd_reg;
    assign m_reg_a        = o_a_reg;
    assign m_reg_x        = o_x_reg;
    assign m_reg_y        = o_y_reg;
    assign m_stack_ptr    = o_sp_reg;
    assign m_prog_counter = o_pc_reg;
    assign m_flags_byte   = o_f_reg;
    assign m_opcode_done  = o_op_reg;

    // Checks
    a_flag_u_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_reg[FB_U]) else $error("status bit 5 stored as set");

    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_OPH || state_reg == ST_PTRH ||
                    state_reg == ST_OPND || state_reg == ST_PUSH))
        else $error("memory write outside an access state");

    a_exec_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_EXEC) |=> (state_reg == ST_OPC))
        else $error("execute beat did not start opcode fetch");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not presented after completion");

endmodule

`default_nettype wire
